// ----- rtl/gblur_pkg.sv -----
// Shared constants, types and helper functions for the 5x5 Gaussian blur stream.
package gblur_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned DIM_W      = 12;
  localparam int unsigned KDIM       = 5;
  localparam int unsigned EDGE       = 4;
  localparam int unsigned NORM_SHIFT = 8;
  localparam int unsigned LINE_W     = (KDIM - 1) * PIX_W;
  localparam int unsigned VSUM_W     = 12;  // 16 * 255 fits
  localparam int unsigned TAP_W      = 3;
  localparam int unsigned TERM_W     = 16;  // 256 * 255 fits

  // APB register indexes (paddr[2])
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 12'd1280;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 12'd720;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [VSUM_W-1:0] vsum_t;
  typedef logic [TAP_W-1:0]  tap_t;
  typedef logic [TERM_W-1:0] term_t;

  // Per-word control that rides along the pipeline
  typedef struct packed {
    pix_t pix;
    logic pass;
    logic last;
  } stage_t;

  // Binomial tap 1 4 6 4 1
  function automatic tap_t tap_weight(input int unsigned idx);
    tap_t w;
    case (idx) inside
      0, 4:    w = 3'd1;
      1, 3:    w = 3'd4;
      2:       w = 3'd6;
      default: w = 3'd0;
    endcase
    return w;
  endfunction

  // Vertical weighted sum of one window column, row 0 oldest
  function automatic vsum_t col_sum(input pix_t p0, input pix_t p1, input pix_t p2,
                                    input pix_t p3, input pix_t p4);
    vsum_t s;
    s = VSUM_W'(p0) + (VSUM_W'(p1) << 2) + (VSUM_W'(p2) << 2) + (VSUM_W'(p2) << 1)
      + (VSUM_W'(p3) << 2) + VSUM_W'(p4);
    return s;
  endfunction

endpackage

// ----- rtl/gaussian_blur_5x5_stream.sv -----
// Top level of the 5x5 Gaussian blur stream: counters, line store, cell chain, output register.
//
// Usage: pixels enter in raster order on in_valid_i/in_ready_o with pixel_in_i; each
// word yields one output word on out_valid_o/out_ready_i carrying pixel_out_o and
// frame_end_o (set on the last pixel of a frame). frame_width and frame_height are
// set over APB (byte 0 and 4) and clamped to 5..MAX; write them only while idle.
// Pixels in the first four rows or columns of a frame pass through unchanged; others
// get the 1-4-6-4-1 binomial blur, normalized by 256.
// Each accepted word goes through the line store read when it is accepted, then the
// shift of the window into the column cells, then the load of the weighted sum into
// the output register.
// Throughput is one pixel per cycle while the output is not stalled; the line store
// does one read and one write each cycle (at the current column and the previous word's).
// Reset clears the row and column counters and the pipeline valid bits and loads the
// default 1280x720 frame size; line store contents stay undefined until written.
// When the receiver stalls with a word held in the output register, the whole
// pipeline freezes and in_ready_o drops; nothing is lost or repeated.
module gaussian_blur_5x5_stream #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // pixel input
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [gblur_pkg::PIX_W-1:0]  pixel_in_i,
  // pixel output
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [gblur_pkg::PIX_W-1:0]  pixel_out_o,
  output logic                         frame_end_o,
  // APB configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned KDIM = gblur_pkg::KDIM;

  // ---------------- configuration ----------------
  logic [gblur_pkg::DIM_W-1:0] frame_width_q, frame_height_q;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= gblur_pkg::FRAME_WIDTH_RST;
      frame_height_q <= gblur_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == gblur_pkg::REG_FRAME_WIDTH) begin
        frame_width_q <= pwdata[gblur_pkg::DIM_W-1:0];
      end else begin
        frame_height_q <= pwdata[gblur_pkg::DIM_W-1:0];
      end
    end
  end

  always_comb begin
    case (paddr[2])
      gblur_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width_q);
      gblur_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height_q);
      default:                     prdata = '0;
    endcase
  end

  // clamp to 5..MAX
  logic [31:0] w_use, h_use;

  always_comb begin
    w_use = 32'(frame_width_q);
    if (w_use < 32'(KDIM)) begin
      w_use = 32'(KDIM);
    end else if (w_use > 32'(MAX_WIDTH)) begin
      w_use = 32'(MAX_WIDTH);
    end
    h_use = 32'(frame_height_q);
    if (h_use < 32'(KDIM)) begin
      h_use = 32'(KDIM);
    end else if (h_use > 32'(MAX_HEIGHT)) begin
      h_use = 32'(MAX_HEIGHT);
    end
  end

  // ---------------- handshake and counters ----------------
  logic          adv, in_acc;
  logic          v1_q, v2_q, out_valid_q;
  logic [CW-1:0] col_cnt_q, col_cnt_d;
  logic [RW-1:0] row_cnt_q, row_cnt_d;
  logic          col_wrap, row_wrap, pass_now;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign in_acc     = in_valid_i && adv;

  assign col_wrap = (32'(col_cnt_q) + 32'd1) >= w_use;
  assign row_wrap = (32'(row_cnt_q) + 32'd1) >= h_use;
  assign pass_now = (32'(row_cnt_q) < 32'(gblur_pkg::EDGE))
                 || (32'(col_cnt_q) < 32'(gblur_pkg::EDGE));

  always_comb begin
    col_cnt_d = col_cnt_q;
    row_cnt_d = row_cnt_q;
    if (in_acc) begin
      if (col_wrap) begin
        col_cnt_d = '0;
        row_cnt_d = row_wrap ? '0 : row_cnt_q + 1'b1;
      end else begin
        col_cnt_d = col_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
      if (adv) begin
        v1_q        <= in_acc;
        v2_q        <= v1_q;
        out_valid_q <= v2_q;
      end
    end
  end

  // ---------------- stage 1: line store access ----------------
  gblur_pkg::stage_t            s1_q, s2_q;
  logic [CW-1:0]                s1_addr_q;
  logic [gblur_pkg::LINE_W-1:0] line_word;
  logic                         wr_en;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q.pix  <= pixel_in_i;
      s1_q.pass <= pass_now;
      s1_q.last <= col_wrap && row_wrap;
      s1_addr_q <= col_cnt_q;
      s2_q      <= s1_q;
    end
  end

  assign wr_en = adv && v1_q;

  gblur_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (adv),
    .rd_addr_i (col_cnt_q),
    .rd_data_o (line_word),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_addr_q),
    .wr_data_i ({s1_q.pix, line_word[gblur_pkg::LINE_W-1:gblur_pkg::PIX_W]})
  );

  // ---------------- stage 2: window column cells ----------------
  gblur_pkg::vsum_t new_vsum;
  gblur_pkg::vsum_t cell_vsum [KDIM];
  gblur_pkg::term_t cell_term [KDIM];

  assign new_vsum = gblur_pkg::col_sum(line_word[7:0], line_word[15:8], line_word[23:16],
                                       line_word[31:24], s1_q.pix);

  // cell KDIM-1 is the newest column; data moves toward cell 0
  for (genvar j = 0; j < KDIM; j++) begin : g_cell
    gblur_pkg::vsum_t feed;
    if (j == KDIM - 1) begin : g_head
      assign feed = new_vsum;
    end else begin : g_body
      assign feed = cell_vsum[j+1];
    end
    gblur_cell u_cell (
      .clk_i    (clk_i),
      .shift_i  (wr_en),
      .weight_i (gblur_pkg::tap_weight(j)),
      .vsum_i   (feed),
      .vsum_o   (cell_vsum[j]),
      .term_o   (cell_term[j])
    );
  end

  // ---------------- stage 3: weighted sum and output register ----------------
  gblur_pkg::term_t win_sum;
  gblur_pkg::pix_t  pixel_out_q;
  logic             frame_end_q;

  always_comb begin
    win_sum = '0;
    for (int k = 0; k < KDIM; k++) begin
      win_sum = win_sum + cell_term[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pixel_out_q <= s2_q.pass ? s2_q.pix
                   : win_sum[gblur_pkg::NORM_SHIFT +: gblur_pkg::PIX_W];
      frame_end_q <= s2_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_out_q;
  assign frame_end_o = frame_end_q;

  // ---------------- assertions ----------------
  // the line store never reads and writes the same column in one cycle
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && in_acc) |-> (s1_addr_q != col_cnt_q))
    else $error("line store read/write collision");

  // the last pixel of a frame brings both counters back to zero
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && col_wrap && row_wrap) |=> (col_cnt_q == '0 && row_cnt_q == '0))
    else $error("counters did not wrap at frame end");

  // an accepted word always reaches stage 1
  a_accept_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> v1_q)
    else $error("accepted word lost at stage 1");

endmodule

// ----- rtl/gblur_cell.sv -----
// One window column cell: holds the column's vertical sum and shifts it to its neighbor.
module gblur_cell (
  input  logic                 clk_i,
  input  logic                 shift_i,
  input  gblur_pkg::tap_t      weight_i,
  input  gblur_pkg::vsum_t     vsum_i,
  output gblur_pkg::vsum_t     vsum_o,
  output gblur_pkg::term_t     term_o
);

  gblur_pkg::vsum_t vsum_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      vsum_q <= vsum_i;
    end
  end

  assign vsum_o = vsum_q;
  assign term_o = gblur_pkg::term_t'(vsum_q) * gblur_pkg::term_t'(weight_i);

endmodule

// ----- rtl/gblur_line_store.sv -----
// Line store: one 32-bit word per column holding the four rows above, registered read.
module gblur_line_store #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  logic                               clk_i,
  input  logic                               rd_en_i,
  input  logic [AW-1:0]                      rd_addr_i,
  output logic [gblur_pkg::LINE_W-1:0]       rd_data_o,
  input  logic                               wr_en_i,
  input  logic [AW-1:0]                      wr_addr_i,
  input  logic [gblur_pkg::LINE_W-1:0]       wr_data_i
);

  logic [gblur_pkg::LINE_W-1:0] mem [DEPTH];
  logic [gblur_pkg::LINE_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
